// File: rtl/f2dt_pkg.sv
// ----------------------------------------------------------------------------
// f2dt_pkg: shared constants for the float-to-decimal-text core
// Field widths, decimal scaling constants, ASCII codes and the fixed-text
// lookup used for infinities, NaN and zero.
// ----------------------------------------------------------------------------
package f2dt_pkg;

    // Channel payload widths
    localparam int W_FLOAT = 32;
    localparam int W_CHAR  = 7;

    // Float decode
    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
    localparam int         EXP_BIAS_ADJ = 149;

    // Decimal exponent estimate: floor(x * 30103 / 100000), x offset positive
    localparam int LOG2_NUM  = 30103;
    localparam int LOG2_DEN  = 100000;
    localparam int LOG_HALF  = 47712;
    localparam int EXP10_OFS = 50;
    localparam int RECIP_SH  = 41;
    localparam longint unsigned RECIP_MUL =
        ((64'd1 << RECIP_SH) + 64'(LOG2_DEN) - 64'd1) / 64'(LOG2_DEN);

    // Wide scaling datapath
    localparam int W_BIG     = 160;
    localparam int W_SIG     = 32;
    localparam int ALIGN_SH  = 31;
    localparam int DIV_STEPS = 32;

    // Text buffer
    localparam int BUF_DEPTH = 16;
    localparam int MAX_DIG   = 10;

    // ASCII codes
    localparam logic [6:0] CH_0     = 7'h30;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_E     = 7'h65;
    localparam logic [6:0] CH_I     = 7'h69;
    localparam logic [6:0] CH_N     = 7'h6E;
    localparam logic [6:0] CH_F     = 7'h66;
    localparam logic [6:0] CH_A     = 7'h61;

    // Fixed three-letter texts
    typedef enum logic [1:0] {
        K_ZERO = 2'd0,
        K_INF  = 2'd1,
        K_NAN  = 2'd2
    } t_kind;

    // What follows the significand digits
    typedef enum logic [1:0] {
        AF_DONE = 2'd0,
        AF_ZERO = 2'd1,
        AF_EXP  = 2'd2
    } t_after;

    function automatic logic [6:0] spec_char(input t_kind kind, input logic [1:0] idx);
        logic [6:0] ch;
        ch = CH_0;
        case (kind)
            K_ZERO: ch = (idx == 2'd1) ? CH_E : CH_0;
            K_INF: begin
                case (idx)
                    2'd0:    ch = CH_I;
                    2'd1:    ch = CH_N;
                    default: ch = CH_F;
                endcase
            end
            K_NAN:   ch = (idx == 2'd1) ? CH_A : CH_N;
            default: ch = CH_0;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/f2dt_if.sv
// ----------------------------------------------------------------------------
// f2dt channel interfaces
// Valid/ready channels: raw float requests in, text characters out.
// ----------------------------------------------------------------------------
interface f2dt_in_if
    import f2dt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [W_FLOAT-1:0] float_bits;

    modport source (output valid, output float_bits, input ready);
    modport sink   (input valid, input float_bits, output ready);
endinterface

interface f2dt_out_if
    import f2dt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [W_CHAR-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: rtl/float32_to_short_decimal_text_core.sv
// ----------------------------------------------------------------------------
// float32_to_short_decimal_text_core: short decimal text of an IEEE single
// Takes one 32-bit float request and streams its decimal text as ASCII
// characters, the final one flagged. Interval bounds are found exactly with a
// shared 160-bit multiply-by-5 / shift / restoring-divide unit.
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  i_in      in    valid/ready     float_bits[31:0]
//  o_out     out   valid/ready     char_code[6:0], last_char
//
//  Per bound, multiply-by-five steps, shift steps and 32 divide steps run
//  through the shared wide unit; then zeros are stripped, digits extracted
//  and text characters built, then the text is streamed out. Special values
//  skip the wide unit. Reset is synchronous, active low, and clears the
//  sequencer and output valid. Output stalls hold the character register; no
//  new request is taken until the last character has been loaded into that
//  register.
// ----------------------------------------------------------------------------
module float32_to_short_decimal_text_core
    import f2dt_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    f2dt_in_if.sink        i_in,
    f2dt_out_if.source     o_out
);

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_EXP10A = 18'h00002,
        S_EXP10B = 18'h00004,
        S_LOAD   = 18'h00008,
        S_MUL    = 18'h00010,
        S_SHL    = 18'h00020,
        S_DIV    = 18'h00040,
        S_COMB   = 18'h00080,
        S_D10    = 18'h00100,
        S_STRIP  = 18'h00200,
        S_DIGX   = 18'h00400,
        S_PREP   = 18'h00800,
        S_LEAD   = 18'h01000,
        S_DIG    = 18'h02000,
        S_ZERO   = 18'h04000,
        S_EXPO   = 18'h08000,
        S_SPEC   = 18'h10000,
        S_OUT    = 18'h20000
    } t_state;

    t_state              r_state;

    // decoded request
    logic                r_neg;
    logic                r_mb_zero;
    logic                r_mb_odd;
    logic [23:0]         r_sig2;
    logic signed [9:0]   r_exp2;
    t_kind               r_kind;

    // scaling
    logic [23:0]         r_y;
    logic signed [7:0]   r_c;
    logic                r_pass;
    logic [W_BIG-1:0]    r_w;
    logic [W_BIG-1:0]    r_d;
    logic [5:0]          r_mc;
    logic [7:0]          r_ws;
    logic [8:0]          r_ds;
    logic [5:0]          r_dc;
    logic [W_SIG-1:0]    r_q;
    logic [W_SIG-1:0]    r_lo;
    logic                r_loi;
    logic [W_SIG-1:0]    r_hi;
    logic                r_hii;

    // decimal significand
    logic [W_SIG-1:0]    r_a;
    logic [W_SIG-1:0]    r_x;
    logic signed [7:0]   r_e;
    logic [3:0]          r_dg [MAX_DIG];
    logic [3:0]          r_n;

    // text build
    logic [3:0]          r_i;
    logic [3:0]          r_dotpos;
    logic                r_doten;
    logic                r_dotp;
    t_after              r_after;
    logic [1:0]          r_zc;
    logic                r_zlead;
    logic                r_lp;
    logic [6:0]          r_ev;
    logic                r_eneg;
    logic [1:0]          r_ep;
    logic [1:0]          r_si;
    logic [W_CHAR-1:0]   r_txt [BUF_DEPTH];
    logic [4:0]          r_len;

    // output register
    logic                r_ov;
    logic [W_CHAR-1:0]   r_oc;
    logic                r_ol;
    logic [3:0]          r_oi;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                in_acc;
    logic [7:0]          in_eb;
    logic [22:0]         in_mb;
    logic signed [31:0]  n_ys;
    logic [48:0]         n_prod;
    logic [26:0]         n_n;
    logic signed [9:0]   n_ebnd;
    logic signed [9:0]   n_k;
    logic [W_BIG-1:0]    n_mul_src;
    logic [W_BIG-1:0]    n_mul;
    logic                n_ge;
    logic [W_BIG-1:0]    n_wq;
    logic [W_SIG-1:0]    n_qn;
    logic [63:0]         n_p10;
    logic [W_SIG-1:0]    n_q10;
    logic [3:0]          n_r10;
    logic [W_SIG-1:0]    n_d10x;
    logic signed [7:0]   n_nexp;
    logic signed [7:0]   n_rem;
    logic [14:0]         n_tp;
    logic [3:0]          n_tens;
    logic [3:0]          n_ones;
    logic                wr_en;
    logic [W_CHAR-1:0]   wr_ch;
    logic                out_free;

    assign in_acc   = i_in.valid && i_in.ready;
    assign in_eb    = i_in.float_bits[30:23];
    assign in_mb    = i_in.float_bits[22:0];
    assign out_free = !r_ov || o_out.ready;

    // decimal exponent numerator, offset to stay positive
    assign n_ys = (r_mb_zero ? (32'(r_exp2) - 32'sd2) * LOG2_NUM + LOG_HALF
                             : 32'(r_exp2) * LOG2_NUM) + EXP10_OFS * LOG2_DEN;
    assign n_prod = 49'(r_y) * 49'(RECIP_MUL);

    // bound numerator and binary exponent for this pass
    assign n_n    = r_pass ? ({2'b0, r_sig2, 1'b0} + 27'd1)
                  : (r_mb_zero ? ({1'b0, r_sig2, 2'b0} - 27'd1)
                               : ({2'b0, r_sig2, 1'b0} - 27'd1));
    assign n_ebnd = r_exp2 - ((r_mb_zero && !r_pass) ? 10'sd2 : 10'sd1);
    assign n_k    = n_ebnd - 10'(r_c);

    // shared wide unit: multiply by five, restoring divide step
    assign n_mul_src = r_c[7] ? r_w : r_d;
    assign n_mul     = n_mul_src + (n_mul_src << 2);
    assign n_ge      = (r_w >= r_d);
    assign n_wq      = n_ge ? (r_w - r_d) : r_w;
    assign n_qn      = {r_q[W_SIG-2:0], n_ge};

    // divide by ten through a reciprocal
    assign n_p10  = 64'(r_x) * 64'h0CCCCCCCD;
    assign n_q10  = 32'(n_p10[63:35]);
    assign n_r10  = 4'(r_x - ((n_q10 << 3) + (n_q10 << 1)));
    assign n_d10x = r_x - 32'(n_r10);

    // placement of the decimal point
    assign n_nexp = -r_e;
    assign n_rem  = n_nexp - ($signed({4'b0, r_n}) - 8'sd1);

    // exponent digits, value below 64
    assign n_tp   = 15'(r_ev) * 15'd205;
    assign n_tens = n_tp[14:11];
    assign n_ones = 4'(r_ev - 7'({3'b0, n_tens}) * 7'd10);

    // character written to the text buffer this cycle
    always_comb begin
        wr_en = 1'b0;
        wr_ch = CH_0;
        case (r_state)
            S_LEAD: begin
                wr_en = 1'b1;
                wr_ch = r_lp ? CH_DOT : CH_0;
            end
            S_ZERO: begin
                wr_en = (r_zc != 2'd0);
                wr_ch = CH_0;
            end
            S_DIG: begin
                wr_en = 1'b1;
                wr_ch = r_dotp ? CH_DOT : (CH_0 + 7'(r_dg[r_i]));
            end
            S_EXPO: begin
                case (r_ep)
                    2'd0: begin
                        wr_en = 1'b1;
                        wr_ch = CH_E;
                    end
                    2'd1: begin
                        wr_en = r_eneg;
                        wr_ch = CH_MINUS;
                    end
                    2'd2: begin
                        wr_en = (n_tens != 4'd0);
                        wr_ch = CH_0 + 7'(n_tens);
                    end
                    default: begin
                        wr_en = 1'b1;
                        wr_ch = CH_0 + 7'(n_ones);
                    end
                endcase
            end
            S_SPEC: begin
                wr_en = 1'b1;
                wr_ch = spec_char(r_kind, r_si);
            end
            default: begin
                wr_en = 1'b0;
                wr_ch = CH_0;
            end
        endcase
    end

    // text buffer, sign goes in first at request time
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_txt[0] <= CH_MINUS;
        end else if (wr_en && (r_len < 5'(BUF_DEPTH))) begin
            r_txt[r_len[3:0]] <= wr_ch;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= 5'd0;
            r_ov    <= 1'b0;
        end else begin
            // drained character; in S_OUT the next one may replace it
            if (r_ov && o_out.ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            if (wr_en && (r_len < 5'(BUF_DEPTH))) begin
                r_len <= r_len + 5'd1;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_neg     <= i_in.float_bits[31];
                        r_mb_zero <= (in_mb == 23'd0);
                        r_mb_odd  <= in_mb[0];
                        r_sig2    <= {(in_eb != 8'd0), in_mb};
                        r_exp2    <= $signed({2'b0, in_eb}) - 10'sd149
                                     - ((in_eb != 8'd0) ? 10'sd1 : 10'sd0);
                        r_oi      <= 4'd0;
                        r_si      <= 2'd0;
                        r_len     <= (i_in.float_bits[31] &&
                                      !(in_eb == EXP_ALL_ONES && in_mb != 23'd0))
                                     ? 5'd1 : 5'd0;
                        if (in_eb == EXP_ALL_ONES) begin
                            r_kind  <= (in_mb == 23'd0) ? K_INF : K_NAN;
                            r_state <= S_SPEC;
                        end else if (in_eb == 8'd0 && in_mb == 23'd0) begin
                            r_kind  <= K_ZERO;
                            r_state <= S_SPEC;
                        end else begin
                            r_state <= S_EXP10A;
                        end
                    end
                end

                S_EXP10A: begin
                    r_y     <= n_ys[23:0];
                    r_state <= S_EXP10B;
                end

                S_EXP10B: begin
                    r_c     <= $signed(n_prod[48:41] - 8'(EXP10_OFS));
                    r_e     <= $signed(n_prod[48:41] - 8'(EXP10_OFS));
                    r_pass  <= 1'b0;
                    r_state <= S_LOAD;
                end

                // set up one bound: n * 5^-c * 2^k over 5^c
                S_LOAD: begin
                    r_w     <= W_BIG'(n_n);
                    r_d     <= W_BIG'(1);
                    r_mc    <= r_c[7] ? 6'(-r_c) : 6'(r_c);
                    r_ws    <= (n_k > 10'sd0) ? n_k[7:0] : 8'd0;
                    r_ds    <= ((n_k < 10'sd0) ? 9'(-n_k) : 9'd0) + 9'(ALIGN_SH);
                    r_state <= S_MUL;
                end

                S_MUL: begin
                    if (r_mc != 6'd0) begin
                        if (r_c[7]) begin
                            r_w <= n_mul;
                        end else begin
                            r_d <= n_mul;
                        end
                        r_mc <= r_mc - 6'd1;
                    end else begin
                        r_state <= S_SHL;
                    end
                end

                S_SHL: begin
                    if (r_ws != 8'd0) begin
                        r_w  <= r_w << 1;
                        r_ws <= r_ws - 8'd1;
                    end else if (r_ds != 9'd0) begin
                        r_d  <= r_d << 1;
                        r_ds <= r_ds - 9'd1;
                    end else begin
                        r_dc    <= 6'(DIV_STEPS);
                        r_q     <= '0;
                        r_state <= S_DIV;
                    end
                end

                // one quotient bit per cycle
                S_DIV: begin
                    r_w  <= n_wq;
                    r_q  <= n_qn;
                    r_d  <= r_d >> 1;
                    r_dc <= r_dc - 6'd1;
                    if (r_dc == 6'd1) begin
                        if (!r_pass) begin
                            r_lo    <= n_qn;
                            r_loi   <= (n_wq != '0);
                            r_pass  <= 1'b1;
                            r_state <= S_LOAD;
                        end else begin
                            r_hi    <= n_qn;
                            r_hii   <= (n_wq != '0);
                            r_state <= S_COMB;
                        end
                    end
                end

                S_COMB: begin
                    if (r_mb_odd) begin
                        r_a <= r_lo + 32'd1;
                        r_x <= r_hi + 32'(r_hii) - 32'd1;
                    end else begin
                        r_a <= r_lo + 32'(r_loi);
                        r_x <= r_hi;
                    end
                    r_state <= S_D10;
                end

                // prefer a significand with a trailing zero
                S_D10: begin
                    if (n_d10x > r_a) begin
                        r_x <= n_q10;
                        r_e <= r_e + 8'sd1;
                        if (n_q10 == '0) begin
                            r_kind  <= K_ZERO;
                            r_state <= S_SPEC;
                        end else begin
                            r_state <= S_STRIP;
                        end
                    end else if (r_x == '0) begin
                        r_kind  <= K_ZERO;
                        r_state <= S_SPEC;
                    end else begin
                        r_state <= S_STRIP;
                    end
                end

                S_STRIP: begin
                    if (n_r10 == 4'd0) begin
                        r_x <= n_q10;
                        r_e <= r_e + 8'sd1;
                    end else begin
                        r_n     <= 4'd0;
                        r_state <= S_DIGX;
                    end
                end

                // digits, least significant first
                S_DIGX: begin
                    r_dg[r_n] <= n_r10;
                    r_n       <= r_n + 4'd1;
                    r_x       <= n_q10;
                    if (n_q10 == '0) begin
                        r_state <= S_PREP;
                    end
                end

                // choose the layout
                S_PREP: begin
                    r_i     <= r_n - 4'd1;
                    r_dotp  <= 1'b0;
                    r_zlead <= 1'b0;
                    r_lp    <= 1'b0;
                    r_ep    <= 2'd0;
                    if (!r_e[7]) begin
                        r_dotpos <= 4'd0;
                        r_doten  <= 1'b0;
                        r_eneg   <= 1'b0;
                        if (r_e > 8'sd2) begin
                            r_after <= AF_EXP;
                            r_ev    <= 7'(r_e);
                            r_zc    <= 2'd0;
                        end else begin
                            r_after <= AF_ZERO;
                            r_ev    <= 7'd0;
                            r_zc    <= 2'(r_e);
                        end
                        r_state <= S_DIG;
                    end else if (n_rem <= 8'sd0) begin
                        r_dotpos <= 4'(n_nexp);
                        r_doten  <= 1'b1;
                        r_after  <= AF_DONE;
                        r_ev     <= 7'd0;
                        r_eneg   <= 1'b0;
                        r_zc     <= 2'd0;
                        r_state  <= S_DIG;
                    end else if (n_rem > 8'sd2) begin
                        r_dotpos <= r_n - 4'd1;
                        r_doten  <= (r_n > 4'd1);
                        r_after  <= AF_EXP;
                        r_ev     <= 7'(n_rem);
                        r_eneg   <= 1'b1;
                        r_zc     <= 2'd0;
                        r_state  <= S_DIG;
                    end else begin
                        r_dotpos <= 4'd0;
                        r_doten  <= 1'b0;
                        r_after  <= AF_DONE;
                        r_ev     <= 7'd0;
                        r_eneg   <= 1'b0;
                        r_zc     <= 2'(n_rem - 8'sd1);
                        r_state  <= S_LEAD;
                    end
                end

                // leading "0."
                S_LEAD: begin
                    if (!r_lp) begin
                        r_lp <= 1'b1;
                    end else begin
                        r_zlead <= 1'b1;
                        r_state <= S_ZERO;
                    end
                end

                S_ZERO: begin
                    if (r_zc != 2'd0) begin
                        r_zc <= r_zc - 2'd1;
                    end else if (r_zlead) begin
                        r_zlead <= 1'b0;
                        r_state <= S_DIG;
                    end else begin
                        r_state <= S_OUT;
                    end
                end

                // digits, most significant first, point after its digit
                S_DIG: begin
                    if (r_dotp) begin
                        r_dotp <= 1'b0;
                    end else begin
                        if (r_doten && (r_i == r_dotpos)) begin
                            r_dotp <= 1'b1;
                        end
                        if (r_i == 4'd0) begin
                            case (r_after)
                                AF_ZERO: r_state <= S_ZERO;
                                AF_EXP:  r_state <= S_EXPO;
                                default: r_state <= S_OUT;
                            endcase
                        end else begin
                            r_i <= r_i - 4'd1;
                        end
                    end
                end

                S_EXPO: begin
                    r_ep <= r_ep + 2'd1;
                    if (r_ep == 2'd3) begin
                        r_state <= S_OUT;
                    end
                end

                S_SPEC: begin
                    r_si <= r_si + 2'd1;
                    if (r_si == 2'd2) begin
                        r_state <= S_OUT;
                    end
                end

                // hand the buffer over one character at a time
                S_OUT: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_oc <= r_txt[r_oi];
                        r_ol <= ({1'b0, r_oi} == (r_len - 5'd1));
                        r_oi <= r_oi + 4'd1;
                        if ({1'b0, r_oi} == (r_len - 5'd1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.char_code = r_oc;
    assign o_out.last_char = r_ol;

endmodule

// File: tb/tb_f2dt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_f2dt_checker: text predictor and scoreboard for the float-to-text core
// Watches both channels. Each accepted float request is turned into its
// expected character string; each accepted character is compared in order.
// ----------------------------------------------------------------------------
module tb_f2dt_checker
    import f2dt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    f2dt_in_if          i_in,
    f2dt_out_if         i_out,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [W_CHAR-1:0] code;
        logic              last;
    } t_char;

    t_char char_queue[$];
    int    fail_count;

    assign o_fail_count = fail_count;

    // exact floor(n * 2^e / 10^c) with sticky flag
    function automatic logic [31:0] scaled_floor(input logic [31:0] n, input int e,
                                                 input int c, output bit inexact);
        logic [223:0] w;
        int           k;
        k = e - c;
        w = 224'(n);
        inexact = 0;
        for (int i = 0; i < -c; i++) w = w * 5;
        if (k > 0) w = w << k;
        for (int i = 0; i < c; i++) begin
            if (w % 5 != 0) inexact = 1;
            w = w / 5;
        end
        for (int i = 0; i < -k; i++) begin
            if (w[0]) inexact = 1;
            w = w >> 1;
        end
        return w[31:0];
    endfunction

    function automatic int div_round_down(input int a, input int b);
        return a / b - ((a % b != 0 && a < 0) ? 1 : 0);
    endfunction

    function automatic string u32_text(input logic [31:0] x);
        string s;
        s = "";
        do begin
            s = {string'(byte'(8'h30 + x % 10)), s};
            x = x / 10;
        end while (x != 0);
        return s;
    endfunction

    // decimal text of sig * 10^ex after stripping zeros
    function automatic string decimal_text(input logic [31:0] sig, input int ex);
        string ds, s;
        int    n, nexp, rem;
        while (sig % 10 == 0) begin
            sig = sig / 10;
            ex++;
        end
        if (ex >= 0) begin
            s = u32_text(sig);
            if (ex > 2) return {s, "e", u32_text(ex)};
            for (int i = 0; i < ex; i++) s = {s, "0"};
            return s;
        end
        ds   = u32_text(sig);
        n    = ds.len();
        nexp = -ex;
        rem  = nexp - (n - 1);
        s    = "";
        if (rem <= 0) begin
            for (int i = 0; i < n; i++) begin
                s = {s, string'(ds[i])};
                if (n - 1 - i == nexp) s = {s, "."};
            end
        end else if (rem > 2) begin
            s = string'(ds[0]);
            if (n > 1) s = {s, ".", ds.substr(1, n - 1)};
            s = {s, "e-", u32_text(rem)};
        end else begin
            s = "0.";
            for (int i = 1; i < rem; i++) s = {s, "0"};
            s = {s, ds};
        end
        return s;
    endfunction

    function automatic string float_text(input logic [31:0] bits);
        logic        neg;
        logic [7:0]  eb;
        logic [22:0] mb;
        logic [31:0] sig2, lo_fl, hi_fl, a, b, d, sig10;
        int          exp2, exp10;
        bit          lo_inx, hi_inx;
        string       sg;
        neg  = bits[31];
        eb   = bits[30:23];
        mb   = bits[22:0];
        sig2 = {9'd0, mb};
        exp2 = int'(eb) - EXP_BIAS_ADJ;
        if (eb == EXP_ALL_ONES) return (mb != 0) ? "nan" : (neg ? "-inf" : "inf");
        sg = neg ? "-" : "";
        if (eb == 0 && mb == 0) return {sg, "0e0"};
        if (eb != 0) begin
            sig2[23] = 1'b1;
            exp2--;
        end
        if (mb != 0) begin
            exp10 = div_round_down(exp2 * LOG2_NUM, LOG2_DEN);
            lo_fl = scaled_floor(2 * sig2 - 1, exp2 - 1, exp10, lo_inx);
        end else begin
            exp10 = div_round_down((exp2 - 2) * LOG2_NUM + LOG_HALF, LOG2_DEN);
            lo_fl = scaled_floor(4 * sig2 - 1, exp2 - 2, exp10, lo_inx);
        end
        hi_fl = scaled_floor(2 * sig2 + 1, exp2 - 1, exp10, hi_inx);
        if (mb[0]) begin
            a = lo_fl + 1;
            b = hi_fl + (hi_inx ? 1 : 0) - 1;
        end else begin
            a = lo_fl + (lo_inx ? 1 : 0);
            b = hi_fl;
        end
        d = b / 10;
        if (d * 10 > a) begin
            sig10 = d;
            exp10++;
        end else begin
            sig10 = b;
        end
        if (sig10 == 0) return {sg, "0e0"};
        return {sg, decimal_text(sig10, exp10)};
    endfunction

    // predict on request, compare on character
    always @(posedge i_clk) begin
        string txt;
        t_char exp_ch;
        byte   ch_b;
        if (!i_rst_n) begin
            char_queue.delete();
            fail_count <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                txt = float_text(i_in.float_bits);
                for (int i = 0; i < txt.len() && i < BUF_DEPTH; i++) begin
                    ch_b = txt[i];
                    char_queue.push_back('{ch_b[6:0], i == txt.len() - 1});
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (char_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected char %h last %b", i_out.char_code,
                                 i_out.last_char);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_ch = char_queue.pop_front();
                    if (exp_ch.code !== i_out.char_code || exp_ch.last !== i_out.last_char)
                    begin
                        if (fail_count < 10)
                            $display("char mismatch: exp %h/%b got %h/%b", exp_ch.code,
                                     exp_ch.last, i_out.char_code, i_out.last_char);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        o_pending <= char_queue.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: float-to-decimal-text core testbench
// Directed special and ordinary values then random floats weighted to every exponent
// class, with random idling on both channels; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top
    import f2dt_pkg::*;
;

    localparam int N_RANDOM   = 460;
    localparam int WDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending;
    int   idle_cycles;
    bit   quiet;

    logic [31:0] directed[$] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001,
        32'h8000_0001, 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF,
        32'hFF7F_FFFF, 32'h3F80_0000, 32'hBF80_0000, 32'h3DCC_CCCD,
        32'h4120_0000, 32'h42C8_0000, 32'h447A_0000, 32'h4B18_9680,
        32'h3C23_D70A, 32'h3A83_126F, 32'h3EAA_AAAB, 32'h4049_0FDB,
        32'h5555_5555
    };

    f2dt_in_if  in_ch ();
    f2dt_out_if out_ch ();

    float32_to_short_decimal_text_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    tb_f2dt_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // output stall bursts
    initial begin
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 17);
                out_ch.ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_float(input logic [31:0] bits);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 17);
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.float_bits <= bits;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic logic [31:0] random_float();
        logic [7:0]  ex;
        logic [22:0] man;
        case ($urandom_range(0, 9))
            0:       ex = 8'd0;
            1:       ex = EXP_ALL_ONES;
            2:       ex = 8'd254;
            3:       ex = 8'd1;
            default: ex = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 6))
            0:       man = 23'd0;
            1:       man = 23'h7FFFFF;
            2:       man = 23'(1) << $urandom_range(0, 22);
            default: man = 23'($urandom);
        endcase
        return {1'($urandom), ex, man};
    endfunction

    initial begin
        quiet          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.float_bits = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send_float(directed[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 40) quiet = 1'b1;
            send_float(random_float());
        end
        in_ch.valid <= 1'b0;
        // let the last prediction land before watching the queue drain
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/f2dt_pkg.sv
rtl/f2dt_if.sv
rtl/float32_to_short_decimal_text_core.sv
tb/tb_f2dt_checker.sv
tb/tb_top.sv
